// ----- rtl/snfcs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snfcs_pkg: shared types and constants
// Request and result structs, request codes and result kinds.
// ----------------------------------------------------------------------------
package snfcs_pkg;

	localparam int PAGE_BYTES     = 256;
	localparam int SECTOR_BYTES   = 4096;
	localparam int MAX_READ_BYTES = 65536;

	localparam logic [2:0] REQ_ID     = 3'd0;
	localparam logic [2:0] REQ_UID    = 3'd1;
	localparam logic [2:0] REQ_STATUS = 3'd2;
	localparam logic [2:0] REQ_READ   = 3'd3;
	localparam logic [2:0] REQ_PROG   = 3'd4;
	localparam logic [2:0] REQ_ERASE  = 3'd5;
	localparam logic [2:0] REQ_BYTE   = 3'd6;

	localparam logic [2:0] K_SEND   = 3'd0;
	localparam logic [2:0] K_READ   = 3'd1;
	localparam logic [2:0] K_ID     = 3'd2;
	localparam logic [2:0] K_STATUS = 3'd3;
	localparam logic [2:0] K_DONE   = 3'd4;

	localparam logic [0:0] ADDR_FILLER = 1'b0;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [1:0]  status_select;
		logic [23:0] flash_address;
		logic [11:0] sector_index;
		logic [16:0] byte_count;
		logic [7:0]  program_byte;
		logic [7:0]  returned_byte;
	} req_t;

	typedef struct packed {
		logic [2:0]  result_kind;
		logic [7:0]  send_byte;
		logic        end_frame;
		logic [23:0] result_value;
		logic [10:0] block_count;
		logic        last;
	} rsp_t;

	// one queue entry: up to two results from one request
	typedef struct packed {
		logic two;
		rsp_t r0;
		rsp_t r1;
	} pair_t;

	function automatic rsp_t mk(input logic [2:0] k, input logic [7:0] sb,
			input logic ef, input logic [23:0] v, input logic [10:0] bc);
		rsp_t r;
		r.result_kind = k;
		r.send_byte = sb;
		r.end_frame = ef;
		r.result_value = v;
		r.block_count = bc;
		r.last = 1'b0;
		return r;
	endfunction

endpackage

// ----- rtl/snfcs_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snfcs_front: sequence engine
// Accepts requests, advances the command sequence, emits result pairs.
// ----------------------------------------------------------------------------
module snfcs_front import snfcs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  req_t       in_data,
	input  logic [7:0] filler,
	output logic       push,
	input  logic       q_full,
	output pair_t      push_data
);

	localparam logic [4:0] PH_IDLE = 5'd0, PH_ID_FIRST = 5'd1, PH_ID_DATA = 5'd2,
		PH_UID_DUMMY = 5'd3, PH_UID_DATA = 5'd4, PH_ST_FILL = 5'd5, PH_ST_DATA = 5'd6,
		PH_CMD = 5'd7, PH_ADDR_HI = 5'd8, PH_ADDR_MID = 5'd9, PH_ADDR_LO = 5'd10,
		PH_DUMMY = 5'd11, PH_XFER_START = 5'd12, PH_XFER = 5'd13, PH_POLL_CMD = 5'd14,
		PH_POLL_FILL = 5'd15, PH_POLL_CHECK = 5'd16;

	logic [4:0]  phase_q, phase_d;
	logic [2:0]  cmd_q, cmd_d;
	logic [23:0] addr_q, addr_d;
	logic [16:0] left_q, left_d;
	logic [23:0] acc_q, acc_d;
	logic [1:0]  sel_q, sel_d;
	logic        n0, n1;
	rsp_t        a, b;
	logic        acc_go;
	logic [23:0] nid;

	function automatic logic [10:0] blocks_of(input logic [7:0] c);
		logic [10:0] r;
		r = 11'd0;
		if (c == 8'h20) r = 11'd1024;
		else if (c >= 8'h11 && c <= 8'h19) r = 11'd1 << (c[3:0] - 4'd0);
		return r;
	endfunction

	assign in_ready = !q_full;
	assign acc_go = in_valid && in_ready;
	assign nid = {acc_q[15:0], in_data.returned_byte};

	always_comb begin
		logic [7:0] sb;
		logic [16:0] c;
		phase_d = phase_q; cmd_d = cmd_q; addr_d = addr_q; left_d = left_q;
		acc_d = acc_q; sel_d = sel_q;
		n0 = 1'b0; n1 = 1'b0;
		a = mk(K_SEND, 8'd0, 1'b0, 24'd0, 11'd0);
		b = a;
		sb = 8'd0;
		c = 17'd0;
		if (in_data.req_type <= REQ_ERASE) begin
			if (phase_q == PH_IDLE) begin
				cmd_d = in_data.req_type;
				n0 = 1'b1;
				case (in_data.req_type)
					REQ_ID: begin
						acc_d = 24'd0; a.send_byte = 8'h9F; phase_d = PH_ID_FIRST;
					end
					REQ_UID: begin
						left_d = 17'd4; a.send_byte = 8'h4B; phase_d = PH_UID_DUMMY;
					end
					REQ_STATUS: begin
						sel_d = in_data.status_select;
						a.send_byte = (in_data.status_select == 2'd1) ? 8'h05 :
							(in_data.status_select == 2'd2) ? 8'h35 : 8'h15;
						phase_d = PH_ST_FILL;
					end
					REQ_READ: begin
						addr_d = in_data.flash_address;
						c = in_data.byte_count;
						left_d = (c > 17'(MAX_READ_BYTES)) ? 17'(MAX_READ_BYTES) : c;
						a.send_byte = 8'h0B; phase_d = PH_ADDR_HI;
					end
					REQ_PROG: begin
						addr_d = in_data.flash_address;
						c = in_data.byte_count;
						left_d = (c > 17'(PAGE_BYTES)) ? 17'(PAGE_BYTES) : c;
						a.send_byte = 8'h06; a.end_frame = 1'b1; phase_d = PH_CMD;
					end
					default: begin
						addr_d = 24'(in_data.sector_index) * 24'(SECTOR_BYTES);
						left_d = 17'd0;
						a.send_byte = 8'h06; a.end_frame = 1'b1; phase_d = PH_CMD;
					end
				endcase
			end
		end else if (in_data.req_type == REQ_BYTE) begin
			case (phase_q)
				PH_ID_FIRST: begin
					n0 = 1'b1; a.send_byte = filler; left_d = 17'd2; phase_d = PH_ID_DATA;
				end
				PH_ID_DATA: begin
					acc_d = nid; n0 = 1'b1;
					if (left_q != 17'd0) begin
						a.send_byte = filler; a.end_frame = (left_q == 17'd1);
						left_d = left_q - 17'd1;
					end else begin
						a = mk(K_ID, 8'd0, 1'b0, nid, blocks_of(nid[7:0]));
						phase_d = PH_IDLE;
					end
				end
				PH_UID_DUMMY: begin
					n0 = 1'b1; a.send_byte = filler;
					if (left_q != 17'd0) left_d = left_q - 17'd1;
					else begin
						left_d = 17'd7; phase_d = PH_UID_DATA;
					end
				end
				PH_UID_DATA: begin
					n0 = 1'b1;
					a = mk(K_ID, 8'd0, 1'b0, {16'd0, in_data.returned_byte}, 11'd0);
					if (left_q != 17'd0) begin
						n1 = 1'b1; b.send_byte = filler; b.end_frame = (left_q == 17'd1);
						left_d = left_q - 17'd1;
					end else phase_d = PH_IDLE;
				end
				PH_ST_FILL: begin
					n0 = 1'b1; a.send_byte = filler; a.end_frame = 1'b1; phase_d = PH_ST_DATA;
				end
				PH_ST_DATA: begin
					n0 = 1'b1;
					a = mk(K_STATUS, 8'd0, 1'b0, {16'd0, in_data.returned_byte}, 11'd0);
					phase_d = PH_IDLE;
				end
				PH_CMD: begin
					n0 = 1'b1; a.send_byte = (cmd_q == REQ_PROG) ? 8'h02 : 8'h20;
					phase_d = PH_ADDR_HI;
				end
				PH_ADDR_HI: begin
					n0 = 1'b1; a.send_byte = addr_q[23:16]; phase_d = PH_ADDR_MID;
				end
				PH_ADDR_MID: begin
					n0 = 1'b1; a.send_byte = addr_q[15:8]; phase_d = PH_ADDR_LO;
				end
				PH_ADDR_LO: begin
					n0 = 1'b1; a.send_byte = addr_q[7:0];
					a.end_frame = (cmd_q == REQ_ERASE) ||
						(cmd_q == REQ_PROG && left_q == 17'd0);
					phase_d = (cmd_q == REQ_READ) ? PH_DUMMY :
						(cmd_q == REQ_PROG) ? PH_XFER_START : PH_POLL_CMD;
				end
				PH_DUMMY: begin
					n0 = 1'b1; a.end_frame = (left_q == 17'd0); phase_d = PH_XFER_START;
				end
				PH_XFER_START, PH_XFER: begin
					sb = (cmd_q == REQ_PROG) ? in_data.program_byte : 8'd0;
					if (left_q == 17'd0) begin
						phase_d = PH_IDLE;
					end else begin
						left_d = left_q - 17'd1; phase_d = PH_XFER;
					end
					if (phase_q == PH_XFER && cmd_q == REQ_READ) begin
						n0 = 1'b1; n1 = 1'b1;
						a = mk(K_READ, 8'd0, 1'b0, {16'd0, in_data.returned_byte}, 11'd0);
						b = (left_q == 17'd0) ? mk(K_DONE, 8'd0, 1'b0, 24'd0, 11'd0) :
							mk(K_SEND, sb, left_q == 17'd1, 24'd0, 11'd0);
					end else begin
						n0 = 1'b1;
						a = (left_q == 17'd0) ? mk(K_DONE, 8'd0, 1'b0, 24'd0, 11'd0) :
							mk(K_SEND, sb, left_q == 17'd1, 24'd0, 11'd0);
					end
				end
				PH_POLL_CMD: begin
					n0 = 1'b1; a.send_byte = 8'h05; phase_d = PH_POLL_FILL;
				end
				PH_POLL_FILL: begin
					n0 = 1'b1; a.send_byte = filler; a.end_frame = 1'b1;
					phase_d = PH_POLL_CHECK;
				end
				PH_POLL_CHECK: begin
					n0 = 1'b1;
					if (in_data.returned_byte[0]) begin
						a.send_byte = 8'h05; phase_d = PH_POLL_FILL;
					end else begin
						a = mk(K_DONE, 8'd0, 1'b0, 24'd0, 11'd0); phase_d = PH_IDLE;
					end
				end
				default: phase_d = PH_IDLE;
			endcase
		end
		if (n1) b.last = 1'b1;
		else a.last = 1'b1;
	end

	assign push = acc_go && n0;
	assign push_data = '{two: n1, r0: a, r1: b};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE; cmd_q <= 3'd0; addr_q <= 24'd0; left_q <= 17'd0;
			acc_q <= 24'd0; sel_q <= 2'd1;
		end else if (acc_go) begin
			phase_q <= phase_d; cmd_q <= cmd_d; addr_q <= addr_d; left_q <= left_d;
			acc_q <= acc_d; sel_q <= sel_d;
		end
	end

`ifndef SYNTHESIS
	a_idle_legal: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q <= PH_POLL_CHECK) else $error("phase out of range");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !push) else $error("push into full queue");
	a_two_needs_one: assert property (@(posedge clk) disable iff (!arst_n)
		(push && push_data.two) |-> !push_data.r0.last) else $error("bad last");
`endif

endmodule

// ----- rtl/snfcs_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snfcs_back: result queue and drain
// Two-entry queue of result pairs; unpacks each pair onto the output.
// ----------------------------------------------------------------------------
module snfcs_back import snfcs_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  pair_t push_data,
	output logic  q_full,
	output logic  out_valid,
	input  logic  out_ready,
	output rsp_t  out_data
);

	pair_t      ent_q [2];
	logic       wp_q, rp_q, half_q;
	logic [1:0] cnt_q;
	logic       pop_one, pop_pair;

	assign q_full = (cnt_q == 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_data = half_q ? ent_q[rp_q].r1 : ent_q[rp_q].r0;
	assign pop_one = out_valid && out_ready;
	assign pop_pair = pop_one && (half_q || !ent_q[rp_q].two);

	always_ff @(posedge clk) begin
		if (push) ent_q[wp_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; half_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop_pair) begin
				rp_q <= !rp_q; half_q <= 1'b0;
			end else if (pop_one) half_q <= 1'b1;
			cnt_q <= cnt_q + 2'(push) - 2'(pop_pair);
		end
	end

`ifndef SYNTHESIS
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'd2) else $error("queue overflow");
	a_half: assert property (@(posedge clk) disable iff (!arst_n)
		half_q |-> (out_valid && ent_q[rp_q].two)) else $error("half pointer stray");
	a_lastpair: assert property (@(posedge clk) disable iff (!arst_n)
		pop_pair |-> out_data.last) else $error("pair end without last");
`endif

endmodule

// ----- rtl/spi_nor_flash_command_sequencer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_nor_flash_command_sequencer: serial NOR flash command sequencer
// Issues ID, status, read, program and erase byte sequences on request.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake
// in      | input     | in_valid / in_ready, payload in_data (req_t)
// out     | output    | out_valid / out_ready, payload out_data (rsp_t)
// apb     | input     | psel/penable/pwrite, filler byte at address 0
//
// One request a cycle while in_ready is high; each makes zero, one or two result
// items. The front engine updates the sequence state in the accepting cycle; a
// two-entry queue of result pairs decouples it from the output, which drains
// one item a cycle while out_ready is high. in_ready drops only while the queue
// is full. Reset clears the phase to idle and the filler byte to 0xA5.
module spi_nor_flash_command_sequencer import snfcs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  req_t        in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output rsp_t        out_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [0:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [7:0] filler_q;
	logic       push, q_full;
	pair_t      push_data;

	// register write: filler byte only
	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_FILLER) ? {24'd0, filler_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filler_q <= 8'hA5;
		end else if (psel && penable && pwrite && paddr == ADDR_FILLER) begin
			filler_q <= pwdata[7:0];
		end
	end

	snfcs_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .in_data,
		.filler(filler_q), .push, .q_full, .push_data
	);

	snfcs_back u_back (
		.clk, .arst_n, .push, .push_data, .q_full, .out_valid, .out_ready, .out_data
	);

`ifndef SYNTHESIS
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == !q_full) else $error("ready mismatch");
	a_pready: assert property (@(posedge clk) pready) else $error("pready low");
	a_push: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (in_valid && in_ready)) else $error("push without request");
`endif

endmodule

// ----- tb/tb_spi_nor_flash_command_sequencer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_spi_nor_flash_command_sequencer: self-checking bench for the sequencer
// Drives command requests and returned bytes with random gaps, predicts the
// byte stream and captured values, and compares every result in order.
// ----------------------------------------------------------------------------
module tb_spi_nor_flash_command_sequencer;
	import snfcs_pkg::*;

	// sequencer phases, mirrored for prediction
	typedef enum logic [4:0] {
		PH_IDLE, PH_ID_FIRST, PH_ID_DATA, PH_UID_DUMMY, PH_UID_DATA, PH_ST_FILL,
		PH_ST_DATA, PH_CMD, PH_ADDR_HI, PH_ADDR_MID, PH_ADDR_LO, PH_DUMMY,
		PH_XFER_START, PH_XFER, PH_POLL_CMD, PH_POLL_FILL, PH_POLL_CHECK
	} phase_e;

	localparam logic [2:0] REQ_SEVEN = 3'd7;
	localparam int LIMIT = 2000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	req_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	rsp_t out_data;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [0:0] paddr = ADDR_FILLER;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	spi_nor_flash_command_sequencer dut (.*);

	always #5 clk = ~clk;

	// shadow of the sequencer state
	phase_e      sh_phase;
	logic [2:0]  sh_cmd;
	logic [23:0] sh_addr;
	logic [16:0] sh_left;
	logic [23:0] sh_id;
	logic [7:0]  sh_filler;

	rsp_t expected_results[$];
	int   errors = 0;
	int   cycles = 0;
	bit   quiet = 1'b0;  // no idling in the closing part of the run
	int   polls_left;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic rsp_t rsp(logic [2:0] k, logic [7:0] sb, logic ef,
			logic [23:0] v, logic [10:0] bc);
		rsp_t r;
		r = '0;
		r.result_kind = k;
		r.send_byte = sb;
		r.end_frame = ef;
		r.result_value = v;
		r.block_count = bc;
		return r;
	endfunction

	function automatic logic [10:0] part_blocks(logic [23:0] id);
		logic [7:0] c;
		c = id[7:0];
		if (c == 8'h20) return 11'd1024;
		if (c >= 8'h11 && c <= 8'h19) return 11'(1 << (c - 8'h10));
		return 11'd0;
	endfunction

	// predict the results of one accepted request and queue them
	task automatic predict_sequence(input req_t q);
		rsp_t r[$];
		logic e;
		if (q.req_type <= REQ_ERASE) begin
			if (sh_phase == PH_IDLE) begin
				sh_cmd = q.req_type;
				case (q.req_type)
					REQ_ID: begin
						sh_id = '0;
						r.push_back(rsp(K_SEND, 8'h9F, 0, 0, 0));
						sh_phase = PH_ID_FIRST;
					end
					REQ_UID: begin
						sh_left = 4;
						r.push_back(rsp(K_SEND, 8'h4B, 0, 0, 0));
						sh_phase = PH_UID_DUMMY;
					end
					REQ_STATUS: begin
						r.push_back(rsp(K_SEND, q.status_select == 1 ? 8'h05 :
							(q.status_select == 2 ? 8'h35 : 8'h15), 0, 0, 0));
						sh_phase = PH_ST_FILL;
					end
					REQ_READ: begin
						sh_addr = q.flash_address;
						sh_left = q.byte_count > MAX_READ_BYTES ? 17'(MAX_READ_BYTES)
							: q.byte_count;
						r.push_back(rsp(K_SEND, 8'h0B, 0, 0, 0));
						sh_phase = PH_ADDR_HI;
					end
					REQ_PROG: begin
						sh_addr = q.flash_address;
						sh_left = q.byte_count > PAGE_BYTES ? 17'(PAGE_BYTES)
							: q.byte_count;
						r.push_back(rsp(K_SEND, 8'h06, 1, 0, 0));
						sh_phase = PH_CMD;
					end
					default: begin
						sh_addr = 24'({q.sector_index, 12'h000});
						sh_left = 0;
						r.push_back(rsp(K_SEND, 8'h06, 1, 0, 0));
						sh_phase = PH_CMD;
					end
				endcase
			end
		end else if (q.req_type == REQ_BYTE) begin
			case (sh_phase)
				PH_ID_FIRST: begin
					r.push_back(rsp(K_SEND, sh_filler, 0, 0, 0));
					sh_left = 2;
					sh_phase = PH_ID_DATA;
				end
				PH_ID_DATA: begin
					sh_id = {sh_id[15:0], q.returned_byte};
					if (sh_left > 0) begin
						r.push_back(rsp(K_SEND, sh_filler, sh_left == 1, 0, 0));
						sh_left--;
					end else begin
						r.push_back(rsp(K_ID, 0, 0, sh_id, part_blocks(sh_id)));
						sh_phase = PH_IDLE;
					end
				end
				PH_UID_DUMMY: begin
					r.push_back(rsp(K_SEND, sh_filler, 0, 0, 0));
					if (sh_left > 0) sh_left--;
					else begin
						sh_left = 7;
						sh_phase = PH_UID_DATA;
					end
				end
				PH_UID_DATA: begin
					r.push_back(rsp(K_ID, 0, 0, q.returned_byte, 0));
					if (sh_left > 0) begin
						r.push_back(rsp(K_SEND, sh_filler, sh_left == 1, 0, 0));
						sh_left--;
					end else sh_phase = PH_IDLE;
				end
				PH_ST_FILL: begin
					r.push_back(rsp(K_SEND, sh_filler, 1, 0, 0));
					sh_phase = PH_ST_DATA;
				end
				PH_ST_DATA: begin
					r.push_back(rsp(K_STATUS, 0, 0, q.returned_byte, 0));
					sh_phase = PH_IDLE;
				end
				PH_CMD: begin
					r.push_back(rsp(K_SEND, sh_cmd == REQ_PROG ? 8'h02 : 8'h20, 0, 0, 0));
					sh_phase = PH_ADDR_HI;
				end
				PH_ADDR_HI: begin
					r.push_back(rsp(K_SEND, sh_addr[23:16], 0, 0, 0));
					sh_phase = PH_ADDR_MID;
				end
				PH_ADDR_MID: begin
					r.push_back(rsp(K_SEND, sh_addr[15:8], 0, 0, 0));
					sh_phase = PH_ADDR_LO;
				end
				PH_ADDR_LO: begin
					e = (sh_cmd == REQ_ERASE) || (sh_cmd == REQ_PROG && sh_left == 0);
					r.push_back(rsp(K_SEND, sh_addr[7:0], e, 0, 0));
					sh_phase = sh_cmd == REQ_READ ? PH_DUMMY :
						(sh_cmd == REQ_PROG ? PH_XFER_START : PH_POLL_CMD);
				end
				PH_DUMMY: begin
					r.push_back(rsp(K_SEND, 8'h00, sh_left == 0, 0, 0));
					sh_phase = PH_XFER_START;
				end
				PH_XFER_START, PH_XFER: begin
					if (sh_phase == PH_XFER && sh_cmd == REQ_READ)
						r.push_back(rsp(K_READ, 0, 0, q.returned_byte, 0));
					if (sh_left == 0) begin
						r.push_back(rsp(K_DONE, 0, 0, 0, 0));
						sh_phase = PH_IDLE;
					end else begin
						r.push_back(rsp(K_SEND, sh_cmd == REQ_PROG ? q.program_byte : 8'h00,
							sh_left == 1, 0, 0));
						sh_left--;
						sh_phase = PH_XFER;
					end
				end
				PH_POLL_CMD: begin
					r.push_back(rsp(K_SEND, 8'h05, 0, 0, 0));
					sh_phase = PH_POLL_FILL;
				end
				PH_POLL_FILL: begin
					r.push_back(rsp(K_SEND, sh_filler, 1, 0, 0));
					sh_phase = PH_POLL_CHECK;
				end
				PH_POLL_CHECK: begin
					if (q.returned_byte[0]) begin
						r.push_back(rsp(K_SEND, 8'h05, 0, 0, 0));
						sh_phase = PH_POLL_FILL;
					end else begin
						r.push_back(rsp(K_DONE, 0, 0, 0, 0));
						sh_phase = PH_IDLE;
					end
				end
				default: sh_phase = PH_IDLE;
			endcase
		end
		if (r.size() > 0) r[r.size() - 1].last = 1'b1;
		foreach (r[i]) expected_results.push_back(r[i]);
	endtask

	// result side: random stalls, compare against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result %h", $time, out_data);
			end else begin
				rsp_t x;
				x = expected_results.pop_front();
				if (x.result_kind !== out_data.result_kind ||
						x.send_byte !== out_data.send_byte ||
						x.end_frame !== out_data.end_frame ||
						x.result_value !== out_data.result_value ||
						x.block_count !== out_data.block_count ||
						x.last !== out_data.last) begin
					errors++;
					$display("%0t: mismatch expected %h actual %h", $time, x, out_data);
				end
			end
		end
	end

	int stall_left = 0;
	always @(posedge clk) begin
		if (quiet) out_ready <= 1'b1;
		else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else if ($urandom_range(0, 9) == 0) begin
			stall_left <= $urandom_range(1, 13) - 1;
			out_ready <= 1'b0;
		end else out_ready <= 1'b1;
	end

	// present one request, hold it until accepted, then predict;
	// valid stays high into the next request unless an idle burst comes
	task automatic send_request(input req_t q);
		int gap;
		if (!quiet && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 13);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= q;
		do @(posedge clk); while (!in_ready);
		predict_sequence(q);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_filler(input logic [7:0] v);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= ADDR_FILLER; pwdata <= {24'h0, v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		sh_filler = v;
	endtask

	function automatic req_t random_fields();
		req_t q;
		q.req_type = 3'($urandom_range(0, 7));
		q.status_select = 2'($urandom);
		q.flash_address = 24'($urandom);
		q.sector_index = 12'($urandom);
		q.byte_count = $urandom_range(0, 3) == 0 ? 17'($urandom) :
			17'($urandom_range(0, 6));
		q.program_byte = 8'($urandom);
		q.returned_byte = 8'($urandom);
		return q;
	endfunction

	// returned byte: busy bit set while polls remain, random otherwise
	function automatic req_t byte_back();
		req_t q;
		q = random_fields();
		q.req_type = REQ_BYTE;
		if (sh_phase == PH_POLL_CHECK) begin
			q.returned_byte[0] = (polls_left > 0);
		end
		return q;
	endfunction

	// run one well-formed command until idle or 400 further requests, with random content
	task automatic run_command(input req_t q);
		int guard;
		polls_left = $urandom_range(0, 3);
		send_request(q);
		guard = 0;
		while (sh_phase != PH_IDLE && guard < 400) begin
			if (sh_phase == PH_POLL_CHECK && polls_left > 0) polls_left--;
			if ($urandom_range(0, 30) == 0) send_request(random_fields());
			else send_request(byte_back());
			guard++;
		end
	endtask

	typedef struct {
		logic [2:0]  op;
		logic [1:0]  sel;
		logic [23:0] addr;
		logic [11:0] sector;
		logic [16:0] count;
	} row_t;

	// directed table; each row sets the fields of one opening request
	row_t directed[] = '{
		'{REQ_SEVEN,  2'd0, 24'h000000, 12'h000, 17'd0},
		'{REQ_BYTE,   2'd0, 24'h000000, 12'h000, 17'd0},
		'{REQ_ID,     2'd0, 24'h000000, 12'h000, 17'd0},
		'{REQ_UID,    2'd0, 24'h000000, 12'h000, 17'd0},
		'{REQ_STATUS, 2'd1, 24'h000000, 12'h000, 17'd0},
		'{REQ_STATUS, 2'd2, 24'h000000, 12'h000, 17'd0},
		'{REQ_STATUS, 2'd3, 24'h000000, 12'h000, 17'd0},
		'{REQ_STATUS, 2'd0, 24'h000000, 12'h000, 17'd0},
		'{REQ_READ,   2'd0, 24'hFFFFFF, 12'h000, 17'd0},
		'{REQ_READ,   2'd0, 24'h000000, 12'h000, 17'd1},
		'{REQ_READ,   2'd0, 24'h123456, 12'h000, 17'h1FFFF},
		'{REQ_PROG,   2'd0, 24'hFFFFFF, 12'h000, 17'd0},
		'{REQ_PROG,   2'd0, 24'h000000, 12'h000, 17'd3},
		'{REQ_PROG,   2'd0, 24'hABCDEF, 12'h000, 17'h1FFFF},
		'{REQ_ERASE,  2'd0, 24'h000000, 12'h000, 17'd0},
		'{REQ_ERASE,  2'd0, 24'h000000, 12'hFFF, 17'd0}
	};

	initial begin
		req_t q;
		int items;
		rsp_t first_id;
		sh_phase = PH_IDLE; sh_cmd = '0; sh_addr = '0; sh_left = '0;
		sh_id = '0; sh_filler = 8'hA5;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// the filler resets to 0xA5
		psel <= 1'b1; paddr <= ADDR_FILLER; pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[7:0] !== 8'hA5) begin
			errors++;
			$display("%0t: filler expected %h actual %h", $time, 8'hA5, prdata[7:0]);
		end
		psel <= 1'b0; penable <= 1'b0;

		foreach (directed[i]) begin
			q = random_fields();
			q.req_type = directed[i].op;
			q.status_select = directed[i].sel;
			q.flash_address = directed[i].addr;
			q.sector_index = directed[i].sector;
			q.byte_count = directed[i].count;
			if (q.req_type == REQ_ID) begin
				// the first command after reset opens with the JEDEC opcode
				send_request(q);
				first_id = rsp(K_SEND, 8'h9F, 1'b0, 24'd0, 11'd0);
				first_id.last = 1'b1;
				if (expected_results[$] !== first_id) begin
					errors++;
					$display("%0t: id opcode expected %h actual %h", $time, first_id,
						expected_results[$]);
				end
				while (sh_phase != PH_IDLE) begin
					q = byte_back();
					// make the last id byte a known capacity code
					if (sh_phase == PH_ID_DATA && sh_left == 0) q.returned_byte = 8'h18;
					send_request(q);
				end
			end else run_command(q);
		end
		wait_drained();

		// several filler settings, extremes included
		items = 0;
		for (int ph = 0; ph < 4; ph++) begin
			write_filler(ph == 0 ? 8'h00 : ph == 1 ? 8'hFF : 8'($urandom));
			if (ph == 3) quiet = 1'b1;
			while (items < 300 * (ph + 1)) begin
				if ($urandom_range(0, 9) < 8) begin
					q = random_fields();
					q.req_type = 3'($urandom_range(0, 5));
					if (q.req_type == REQ_READ && $urandom_range(0, 15) != 0)
						q.byte_count = 17'($urandom_range(0, 12));
					if (q.req_type == REQ_PROG && $urandom_range(0, 7) != 0)
						q.byte_count = 17'($urandom_range(0, 12));
					run_command(q);
				end else send_request(random_fields());
				items += 10;
			end
			wait_drained();
		end

		if (errors == 0) $display("Verification passed");
		else $display("Verification failed");
		$finish;
	end
endmodule
